>>> sv/gyro_quaternion_integrator_macros.svh
// ----------------------------------------------------------------------------
// gyro quaternion integrator assertion macros
// concurrent assertion shorthands, empty when synthesizing
// ----------------------------------------------------------------------------
`ifndef GYRO_QUATERNION_INTEGRATOR_MACROS_SVH
`define GYRO_QUATERNION_INTEGRATOR_MACROS_SVH
`ifndef SYNTHESIS
`define GQI_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("gqi assertion failed");
`define GQI_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("gqi assertion failed");
`else
`define GQI_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define GQI_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

>>> sv/gqi_pkg.sv
// ----------------------------------------------------------------------------
// gqi_pkg
// shared constants, unit status type and small tables for the integrator
// ----------------------------------------------------------------------------
`default_nettype none
package gqi_pkg;

  localparam int WORD_W      = 64;
  localparam int MUL_DIGIT_W = 4;

  localparam logic signed [63:0] ONE_Q30     = 64'sd1073741824;
  localparam logic signed [63:0] NEG_ONE_Q30 = -64'sd1073741824;
  localparam logic [63:0]        HALF_PI_Q40 = 64'd1727108826222;
  localparam logic signed [63:0] VEC_LIMIT   = 64'sd1073741823;
  localparam logic [15:0]        PERIOD_RESET = 16'd164;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

  // taylor divisors, sine series then cosine series
  function automatic logic [7:0] sin_den(input logic [3:0] i);
    logic [7:0] d;
    case (i)
      4'd0: d = 8'd156;
      4'd1: d = 8'd110;
      4'd2: d = 8'd72;
      4'd3: d = 8'd42;
      4'd4: d = 8'd20;
      default: d = 8'd6;
    endcase
    return d;
  endfunction

  function automatic logic [7:0] cos_den(input logic [3:0] i);
    logic [7:0] d;
    case (i)
      4'd0: d = 8'd182;
      4'd1: d = 8'd132;
      4'd2: d = 8'd90;
      4'd3: d = 8'd56;
      4'd4: d = 8'd30;
      4'd5: d = 8'd12;
      default: d = 8'd2;
    endcase
    return d;
  endfunction

  function automatic logic signed [63:0] clamp_one(input logic signed [63:0] v);
    logic signed [63:0] r;
    if (v > ONE_Q30) r = ONE_Q30;
    else if (v < NEG_ONE_Q30) r = NEG_ONE_Q30;
    else r = v;
    return r;
  endfunction

  // sign of term j of hamilton product component k (b index is j xor k)
  function automatic logic hamilton_neg(input logic [1:0] k, input logic [1:0] j);
    logic n;
    case (k)
      2'd0: n = (j != 2'd0);
      2'd1: n = (j == 2'd3);
      2'd2: n = (j == 2'd1);
      default: n = (j == 2'd2);
    endcase
    return n;
  endfunction

endpackage
`default_nettype wire

>>> sv/gqi_mul.sv
// ----------------------------------------------------------------------------
// gqi_mul
// digit-serial multiplier, one 4-bit digit of b per cycle, low 64 bits
// ----------------------------------------------------------------------------
`default_nettype none
module gqi_mul (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [63:0]       a,
  input  logic [63:0]       b,
  output logic [63:0]       prod,
  output gqi_pkg::unit_stat_t stat
);
  localparam int STEPS = gqi_pkg::WORD_W / gqi_pkg::MUL_DIGIT_W;
  localparam int CNT_W = $clog2(STEPS);

  logic [63:0]      acc;
  logic [63:0]      a_sh;
  logic [63:0]      b_sh;
  logic [63:0]      pp;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic             done;

  assign pp = a_sh * {{(gqi_pkg::WORD_W-gqi_pkg::MUL_DIGIT_W){1'b0}},
                      b_sh[gqi_pkg::MUL_DIGIT_W-1:0]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        acc  <= '0;
        a_sh <= a;
        b_sh <= b;
        cnt  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        acc  <= acc + pp;
        a_sh <= a_sh << gqi_pkg::MUL_DIGIT_W;
        b_sh <= b_sh >> gqi_pkg::MUL_DIGIT_W;
        cnt  <= cnt + 1'b1;
        if (cnt == CNT_W'(STEPS-1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign prod      = acc;
  assign stat.busy = busy;
  assign stat.done = done;
endmodule
`default_nettype wire

>>> sv/gqi_div.sv
// ----------------------------------------------------------------------------
// gqi_div
// bit-serial restoring divider, unsigned 64 by 64, one quotient bit a cycle
// ----------------------------------------------------------------------------
`default_nettype none
module gqi_div (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [63:0]       num,
  input  logic [63:0]       den,
  output logic [63:0]       quo,
  output logic [63:0]       rem,
  output gqi_pkg::unit_stat_t stat
);
  localparam int STEPS = gqi_pkg::WORD_W;
  localparam int CNT_W = $clog2(STEPS);

  logic [63:0]      num_sh;
  logic [63:0]      den_r;
  logic [64:0]      r_try;
  logic [64:0]      diff;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic             done;

  assign r_try = {rem, num_sh[63]};
  assign diff  = r_try - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        num_sh <= num;
        den_r  <= den;
        rem    <= '0;
        quo    <= '0;
        cnt    <= '0;
        busy   <= 1'b1;
      end else if (busy) begin
        num_sh <= num_sh << 1;
        if (!diff[64]) begin
          rem <= diff[63:0];
          quo <= {quo[62:0], 1'b1};
        end else begin
          rem <= r_try[63:0];
          quo <= {quo[62:0], 1'b0};
        end
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(STEPS-1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
endmodule
`default_nettype wire

>>> sv/gqi_sqrt.sv
// ----------------------------------------------------------------------------
// gqi_sqrt
// digit-by-digit integer square root, two radicand bits per cycle
// ----------------------------------------------------------------------------
`default_nettype none
module gqi_sqrt (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [63:0]       radicand,
  output logic [31:0]       root,
  output gqi_pkg::unit_stat_t stat
);
  localparam int STEPS = gqi_pkg::WORD_W / 2;
  localparam int CNT_W = $clog2(STEPS);

  logic [63:0]      xs;
  logic [34:0]      rem;
  logic [34:0]      r2;
  logic [34:0]      trial;
  logic [35:0]      diff;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic             done;

  assign r2    = {rem[32:0], xs[63:62]};
  assign trial = {1'b0, root, 2'b01};
  assign diff  = {1'b0, r2} - {1'b0, trial};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        xs   <= radicand;
        rem  <= '0;
        root <= '0;
        cnt  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        xs <= xs << 2;
        if (!diff[35]) begin
          rem  <= diff[34:0];
          root <= {root[30:0], 1'b1};
        end else begin
          rem  <= r2;
          root <= {root[30:0], 1'b0};
        end
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(STEPS-1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
endmodule
`default_nettype wire

>>> sv/gyro_quaternion_integrator.sv
// ----------------------------------------------------------------------------
// gyro_quaternion_integrator
// gyro rate integration into an attitude quaternion by the exponential map
// ----------------------------------------------------------------------------
// each accepted request carries one three-axis rate sample (Q.11 rad/s) and
// returns the attitude quaternion after the update plus a rotated flag. the
// rotation vector is rate times sample_period; when it is zero the attitude
// is kept and rotated is low. otherwise the half angle is found by square
// root, sine and cosine come from taylor series, the stored quaternion is
// right-multiplied by the rotation quaternion and then renormalized. the block
// works on one sample at a time: a rotating sample makes 44 passes through
// the radix-16 multiplier, 21 passes through the bit-serial divider and two
// square roots, while a zero rotation uses only the multiplier.
// a new request is taken while the previous result still waits on the output.
// sample_period is to be written on the cfg channel only while the block is
// idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none
`include "gyro_quaternion_integrator_macros.svh"
module gyro_quaternion_integrator #(
  parameter int QUAT_WIDTH = 32,
  parameter int RATE_WIDTH = 18
) (
  input  logic        clk,
  input  logic        rst,
  // input request
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [((3*RATE_WIDTH+7)/8)*8-1:0] s_tdata,  // rate_x, rate_y, rate_z
  // result
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [127:0] m_tdata,  // quat_w, quat_x, quat_y, quat_z
  output logic [0:0]   m_tuser,  // rotated
  // sample_period register
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);
  localparam int QFRAC = QUAT_WIDTH - 2;
  localparam int SHL   = (QFRAC >= 30) ? QFRAC - 30 : 0;
  localparam int SHR   = (QFRAC < 30) ? 30 - QFRAC : 0;
  localparam logic [QUAT_WIDTH-1:0] Q_ONE = {2'b01, {QFRAC{1'b0}}};
  localparam logic signed [63:0] QMAX = (64'sd1 <<< (QUAT_WIDTH-1)) - 64'sd1;
  localparam logic signed [63:0] QMIN = -(64'sd1 <<< (QUAT_WIDTH-1));
  localparam logic signed [63:0] BIG_LIM = 64'sd2147483648;

  // sequencer states
  localparam logic [4:0] ST_IDLE  = 5'd0;
  localparam logic [4:0] ST_VMUL  = 5'd1;
  localparam logic [4:0] ST_VSQ   = 5'd2;
  localparam logic [4:0] ST_CHK   = 5'd3;
  localparam logic [4:0] ST_NSQRT = 5'd4;
  localparam logic [4:0] ST_QUAD  = 5'd5;
  localparam logic [4:0] ST_X2    = 5'd6;
  localparam logic [4:0] ST_SINM  = 5'd7;
  localparam logic [4:0] ST_SIND  = 5'd8;
  localparam logic [4:0] ST_SINX  = 5'd9;
  localparam logic [4:0] ST_COSM  = 5'd10;
  localparam logic [4:0] ST_COSD  = 5'd11;
  localparam logic [4:0] ST_BMUL  = 5'd12;
  localparam logic [4:0] ST_BDIV  = 5'd13;
  localparam logic [4:0] ST_PMUL  = 5'd14;
  localparam logic [4:0] ST_ESQ   = 5'd15;
  localparam logic [4:0] ST_NCHK  = 5'd16;
  localparam logic [4:0] ST_NORM  = 5'd17;
  localparam logic [4:0] ST_NDIV  = 5'd18;
  localparam logic [4:0] ST_DONE  = 5'd19;

  // move stored format to Q.30 and back with saturation
  function automatic logic signed [63:0] to_q30(input logic [QUAT_WIDTH-1:0] v);
    logic signed [63:0] w;
    w = signed'({{(64-QUAT_WIDTH){v[QUAT_WIDTH-1]}}, v});
    return (w <<< SHR) >>> SHL;
  endfunction

  function automatic logic [QUAT_WIDTH-1:0] from_q30(input logic signed [63:0] v);
    logic signed [63:0] w;
    w = (v <<< SHL) >>> SHR;
    if (w > QMAX) w = QMAX;
    else if (w < QMIN) w = QMIN;
    return w[QUAT_WIDTH-1:0];
  endfunction

  function automatic logic [31:0] out32(input logic [QUAT_WIDTH-1:0] v);
    logic [63:0] w;
    w = {{(64-QUAT_WIDTH){v[QUAT_WIDTH-1]}}, v};
    return w[31:0];
  endfunction

  logic [4:0]  state;
  logic [3:0]  idx;
  logic        issued;
  logic [15:0] period;
  logic        rotated;

  logic signed [RATE_WIDTH-1:0] rx, ry, rz;
  logic signed [31:0] vx, vy, vz;
  logic [63:0]        sq;
  logic [63:0]        nsq;
  logic [31:0]        n;
  logic [31:0]        norm;
  logic [1:0]         quad;
  logic signed [63:0] x, x2, t, tmp, s, sn;
  logic signed [63:0] b [0:3];
  logic signed [63:0] p [0:3];
  logic signed [63:0] e [0:3];
  logic signed [63:0] a [0:3];
  logic [QUAT_WIDTH-1:0] q [0:3];

  // unit ports
  logic        mul_start, div_start, sqrt_start;
  logic [63:0] mul_a, mul_b, mul_prod;
  logic [63:0] div_num, div_den, div_quo, div_rem;
  logic [63:0] sqrt_in;
  logic [31:0] sqrt_root;
  gqi_pkg::unit_stat_t mul_stat, div_stat, sqrt_stat;
  logic        is_mul, is_div, is_sqrt, op_done;
  logic [2:0]  units_busy;

  logic signed [RATE_WIDTH-1:0] rate_sel;
  logic signed [31:0] v_sel;
  logic signed [63:0] prod_s, prod_q30, v_shift;
  logic signed [31:0] v_clamped;
  logic signed [63:0] div_src, div_qs, t_new, c_val;
  logic               big;

  assign s_tready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;

  assign is_mul  = (state == ST_VMUL) || (state == ST_VSQ) || (state == ST_X2) ||
                   (state == ST_SINM) || (state == ST_SINX) || (state == ST_COSM) ||
                   (state == ST_BMUL) || (state == ST_PMUL) || (state == ST_ESQ);
  assign is_div  = (state == ST_QUAD) || (state == ST_SIND) || (state == ST_COSD) ||
                   (state == ST_BDIV) || (state == ST_NDIV);
  assign is_sqrt = (state == ST_NSQRT) || (state == ST_NORM);

  assign mul_start  = is_mul && !issued;
  assign div_start  = is_div && !issued;
  assign sqrt_start = is_sqrt && !issued;
  assign op_done    = mul_stat.done | div_stat.done | sqrt_stat.done;
  assign units_busy = {mul_stat.busy, div_stat.busy, sqrt_stat.busy};

  // attitude in Q.30 and the normalization inputs
  always_comb begin
    big = 1'b0;
    for (int i = 0; i < 4; i++) begin
      a[i] = to_q30(q[i]);
      if (p[i] >= BIG_LIM || p[i] <= -BIG_LIM) big = 1'b1;
    end
    for (int i = 0; i < 4; i++) begin
      e[i] = big ? (p[i] >>> 3) : p[i];
    end
  end

  assign rate_sel = (idx[1:0] == 2'd0) ? rx : (idx[1:0] == 2'd1) ? ry : rz;
  assign v_sel    = (idx[1:0] == 2'd0) ? vx : (idx[1:0] == 2'd1) ? vy : vz;

  assign prod_s   = signed'(mul_prod);
  assign prod_q30 = prod_s >>> 30;
  assign v_shift  = prod_s >>> 3;
  assign v_clamped = (v_shift > gqi_pkg::VEC_LIMIT) ? 32'sd1073741823 :
                     (v_shift < -gqi_pkg::VEC_LIMIT) ? -32'sd1073741823 :
                     v_shift[31:0];

  // multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      ST_VMUL: begin
        mul_a = {{(64-RATE_WIDTH){rate_sel[RATE_WIDTH-1]}}, rate_sel};
        mul_b = {48'd0, period};
      end
      ST_VSQ: begin
        mul_a = {{32{v_sel[31]}}, v_sel};
        mul_b = {{32{v_sel[31]}}, v_sel};
      end
      ST_X2: begin
        mul_a = x;
        mul_b = x;
      end
      ST_SINM, ST_COSM: begin
        mul_a = x2;
        mul_b = t;
      end
      ST_SINX: begin
        mul_a = x;
        mul_b = t;
      end
      ST_BMUL: begin
        mul_a = sn;
        mul_b = {{32{v_sel[31]}}, v_sel};
      end
      ST_PMUL: begin
        mul_a = a[idx[1:0]];
        mul_b = b[idx[1:0] ^ idx[3:2]];
      end
      ST_ESQ: begin
        mul_a = e[idx[1:0]];
        mul_b = e[idx[1:0]];
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // divider operands, signed numerator over a positive divisor
  always_comb begin
    div_src = '0;
    div_den = 64'd1;
    case (state)
      ST_QUAD: begin
        div_src = signed'({17'd0, n, 15'd0});
        div_den = gqi_pkg::HALF_PI_Q40;
      end
      ST_SIND: begin
        div_src = tmp;
        div_den = {56'd0, gqi_pkg::sin_den(idx)};
      end
      ST_COSD: begin
        div_src = tmp;
        div_den = {56'd0, gqi_pkg::cos_den(idx)};
      end
      ST_BDIV: begin
        div_src = tmp;
        div_den = {32'd0, n};
      end
      ST_NDIV: begin
        div_src = e[idx[1:0]] <<< 30;
        div_den = {32'd0, norm};
      end
      default: begin
        div_src = '0;
        div_den = 64'd1;
      end
    endcase
  end

  assign div_num = div_src[63] ? 64'(-div_src) : div_src;
  assign div_qs  = div_src[63] ? -signed'(div_quo) : signed'(div_quo);
  assign t_new   = gqi_pkg::ONE_Q30 - div_qs;
  assign c_val   = gqi_pkg::clamp_one(t_new);
  assign sqrt_in = (state == ST_NSQRT) ? sq : nsq;

  gqi_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .prod  (mul_prod),
    .stat  (mul_stat)
  );

  gqi_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .quo   (div_quo),
    .rem   (div_rem),
    .stat  (div_stat)
  );

  gqi_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sqrt_start),
    .radicand (sqrt_in),
    .root     (sqrt_root),
    .stat     (sqrt_stat)
  );

  // sequencer: each arithmetic step issues one unit operation and writes its result back
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      idx      <= '0;
      issued   <= 1'b0;
      period   <= gqi_pkg::PERIOD_RESET;
      rotated  <= 1'b0;
      m_tvalid <= 1'b0;
      q[0]     <= Q_ONE;
      q[1]     <= '0;
      q[2]     <= '0;
      q[3]     <= '0;
    end else begin
      if (cfg_valid && cfg_ready) period <= cfg_data;
      if (mul_start || div_start || sqrt_start) issued <= 1'b1;
      else if (op_done) issued <= 1'b0;
      // the done state refills the output register itself
      if (m_tvalid && m_tready && state != ST_DONE) m_tvalid <= 1'b0;

      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            rx  <= s_tdata[RATE_WIDTH-1:0];
            ry  <= s_tdata[2*RATE_WIDTH-1:RATE_WIDTH];
            rz  <= s_tdata[3*RATE_WIDTH-1:2*RATE_WIDTH];
            sq  <= '0;
            nsq <= '0;
            for (int i = 0; i < 4; i++) p[i] <= '0;
            idx   <= '0;
            state <= ST_VMUL;
          end
        end
        ST_VMUL: begin
          if (mul_stat.done) begin
            case (idx[1:0])
              2'd0: vx <= v_clamped;
              2'd1: vy <= v_clamped;
              default: vz <= v_clamped;
            endcase
            if (idx == 4'd2) begin
              idx   <= '0;
              state <= ST_VSQ;
            end else begin
              idx <= idx + 4'd1;
            end
          end
        end
        ST_VSQ: begin
          if (mul_stat.done) begin
            sq <= sq + mul_prod;
            if (idx == 4'd2) begin
              idx   <= '0;
              state <= ST_CHK;
            end else begin
              idx <= idx + 4'd1;
            end
          end
        end
        ST_CHK: begin
          // zero rotation keeps the attitude
          if (sq == 64'd0) begin
            rotated <= 1'b0;
            state   <= ST_DONE;
          end else begin
            state <= ST_NSQRT;
          end
        end
        ST_NSQRT: begin
          if (sqrt_stat.done) begin
            n     <= sqrt_root;
            state <= ST_QUAD;
          end
        end
        ST_QUAD: begin
          // quadrant of the half angle and the Q.30 remainder
          if (div_stat.done) begin
            quad  <= div_quo[1:0];
            x     <= signed'({10'd0, div_rem[63:10]});
            state <= ST_X2;
          end
        end
        ST_X2: begin
          if (mul_stat.done) begin
            x2    <= prod_q30;
            t     <= gqi_pkg::ONE_Q30;
            idx   <= '0;
            state <= ST_SINM;
          end
        end
        ST_SINM: begin
          if (mul_stat.done) begin
            tmp   <= prod_q30;
            state <= ST_SIND;
          end
        end
        ST_SIND: begin
          if (div_stat.done) begin
            t <= t_new;
            if (idx == 4'd5) begin
              idx   <= '0;
              state <= ST_SINX;
            end else begin
              idx   <= idx + 4'd1;
              state <= ST_SINM;
            end
          end
        end
        ST_SINX: begin
          if (mul_stat.done) begin
            s     <= gqi_pkg::clamp_one(prod_q30);
            t     <= gqi_pkg::ONE_Q30;
            state <= ST_COSM;
          end
        end
        ST_COSM: begin
          if (mul_stat.done) begin
            tmp   <= prod_q30;
            state <= ST_COSD;
          end
        end
        ST_COSD: begin
          if (div_stat.done) begin
            t <= t_new;
            if (idx == 4'd6) begin
              // fold the quadrant back into sine and cosine
              case (quad)
                2'd0: begin sn <= s;      b[0] <= c_val;  end
                2'd1: begin sn <= c_val;  b[0] <= -s;     end
                2'd2: begin sn <= -s;     b[0] <= -c_val; end
                default: begin sn <= -c_val; b[0] <= s;   end
              endcase
              idx   <= '0;
              state <= ST_BMUL;
            end else begin
              idx   <= idx + 4'd1;
              state <= ST_COSM;
            end
          end
        end
        ST_BMUL: begin
          if (mul_stat.done) begin
            tmp   <= prod_s;
            state <= ST_BDIV;
          end
        end
        ST_BDIV: begin
          if (div_stat.done) begin
            b[2'(idx[1:0] + 2'd1)] <= div_qs;
            if (idx == 4'd2) begin
              idx   <= '0;
              state <= ST_PMUL;
            end else begin
              idx   <= idx + 4'd1;
              state <= ST_BMUL;
            end
          end
        end
        ST_PMUL: begin
          // hamilton product, one term a cycle group, row by row
          if (mul_stat.done) begin
            if (gqi_pkg::hamilton_neg(idx[3:2], idx[1:0]))
              p[idx[3:2]] <= p[idx[3:2]] - prod_q30;
            else
              p[idx[3:2]] <= p[idx[3:2]] + prod_q30;
            if (idx == 4'd15) begin
              idx   <= '0;
              state <= ST_ESQ;
            end else begin
              idx <= idx + 4'd1;
            end
          end
        end
        ST_ESQ: begin
          if (mul_stat.done) begin
            nsq <= nsq + mul_prod;
            if (idx == 4'd3) begin
              idx   <= '0;
              state <= ST_NCHK;
            end else begin
              idx <= idx + 4'd1;
            end
          end
        end
        ST_NCHK: begin
          rotated <= 1'b1;
          // degenerate product stores an all-zero quaternion
          if (nsq == 64'd0) begin
            for (int i = 0; i < 4; i++) q[i] <= '0;
            state <= ST_DONE;
          end else begin
            state <= ST_NORM;
          end
        end
        ST_NORM: begin
          if (sqrt_stat.done) begin
            norm  <= sqrt_root;
            idx   <= '0;
            state <= ST_NDIV;
          end
        end
        ST_NDIV: begin
          if (div_stat.done) begin
            q[idx[1:0]] <= from_q30(div_qs);
            if (idx == 4'd3) begin
              idx   <= '0;
              state <= ST_DONE;
            end else begin
              idx <= idx + 4'd1;
            end
          end
        end
        ST_DONE: begin
          // hand over once the output register is free
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {out32(q[3]), out32(q[2]), out32(q[1]), out32(q[0])};
            m_tuser  <= rotated;
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // the block is busy right after taking a request
  `GQI_ASSERT_NEXT(a_busy_after_req, clk, rst, s_tvalid && s_tready, !s_tready)
  // the arithmetic units never run at the same time
  `GQI_ASSERT_IMP(a_one_unit, clk, rst, 1'b1, $onehot0(units_busy))
  // a unit only finishes an operation the sequencer is waiting on
  `GQI_ASSERT_IMP(a_done_expected, clk, rst, op_done, issued)
endmodule
`default_nettype wire
